// ===== sv/awd_pkg.sv =====
// Shared types and constants for the area-weighted downsampler.
// No dependencies; awd_dp, awd_ctrl, the top level and the testbench import this package.
package awd_pkg;

  // Configuration register width and reset values
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] SRC_RESET = CFG_W'(2);
  localparam logic [CFG_W-1:0] DST_RESET = CFG_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_COUNT = 1'b0,
    REG_DST_COUNT = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // capture the input sample
    logic mul;       // form overlap weights and products
    logic add;       // accumulate and advance frame state
    logic div_load;  // load the rounding divider
    logic div_step;  // one quotient bit
    logic out_load;  // write the output register
    logic cfg_we;    // configuration write
  } awd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic close;     // this sample closes an output interval
    logic err;       // invalid counts at the last sample of a frame
    logic out_free;  // output register can take a result this cycle
  } awd_sts_t;

endpackage

// ===== sv/awd_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by awd_dp for the rounded division by src_count.
module awd_div #(
  parameter int NUM_W = 30,
  parameter int QUO_W = 16
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den_sh,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic             fits;

  assign fits = (rem_r >= dsh_r);
  assign quo  = quo_r;

  // Load, then subtract the shifted divisor where it fits and walk it down
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= num;
      dsh_r <= den_sh;
      quo_r <= '0;
    end else if (step) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[QUO_W-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

// ===== sv/awd_dp.sv =====
// Datapath: configuration registers, frame state, overlap products,
// accumulator, rounding divider and output register. Uses awd_pkg and awd_div.
module awd_dp #(
  parameter int MAX_COUNT = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  awd_pkg::awd_cmd_t                  cmd,
  output awd_pkg::awd_sts_t                  sts,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  logic [awd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [awd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      out_value,
  output logic                               out_last_of_frame,
  output logic                               out_status
);
  import awd_pkg::*;

  localparam int SW   = $clog2(MAX_COUNT + 1);
  localparam int CW   = (SW > CFG_W) ? SW : CFG_W;
  localparam int EW   = 2 * SW;
  localparam int SUMW = SW + SAMPLE_BITS + 1;

  // Effective source count: zero acts as one, saturate at MAX_COUNT
  function automatic logic [SW-1:0] eff_src(input logic [CFG_W-1:0] src);
    logic [CW-1:0] ext;
    logic [CW-1:0] res;
    ext = CW'(src);
    if (ext == '0) begin
      res = CW'(1);
    end else if (ext > CW'(MAX_COUNT)) begin
      res = CW'(MAX_COUNT);
    end else begin
      res = ext;
    end
    return SW'(res);
  endfunction

  logic [CFG_W-1:0]              src_r, src_nxt;
  logic [CFG_W-1:0]              dst_r, dst_nxt;
  logic                          cfg_hit;
  logic [SW-1:0]                 s_eff, s_eff_new;
  logic [SW-1:0]                 idx_r, idx_nxt;
  logic [EW-1:0]                 a_r, a_nxt;
  logic [EW-1:0]                 dest_r, dest_nxt;
  logic signed [SUMW-1:0]        sum_r, sum_nxt;
  logic signed [SUMW-1:0]        total_c, total_r;
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic [EW-1:0]                 b_c, b_r;
  logic [SW-1:0]                 d_sw, w1_c, w2_c;
  logic                          last_c, inv_c, close_c;
  logic                          last_f, inv_f, close_f;
  logic signed [SUMW-1:0]        p1_c, p2_c, p1_r, p2_r;
  logic                          neg_r;
  logic [SUMW-1:0]               mag_c, num_c, den_sh;
  logic [SAMPLE_BITS-1:0]        quo, val_c;
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_value_r;
  logic                          out_last_r, out_status_r;

  // Decode configuration writes
  always_comb begin
    src_nxt = src_r;
    dst_nxt = dst_r;
    cfg_hit = 1'b0;
    if (cmd.cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_COUNT: begin
          src_nxt = cfg_data;
          cfg_hit = 1'b1;
        end
        REG_DST_COUNT: begin
          dst_nxt = cfg_data;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign s_eff     = eff_src(src_r);
  assign s_eff_new = eff_src(src_nxt);

  // Classify the sample: frame end, invalid counts, interval close
  assign last_c  = ((SW + 1)'(idx_r) + (SW + 1)'(1)) >= (SW + 1)'(s_eff);
  assign inv_c   = (dst_r == '0) || (CW'(dst_r) >= CW'(s_eff));
  assign d_sw    = SW'(dst_r);
  assign b_c     = a_r + EW'(d_sw);
  assign close_c = !inv_c && !(b_c < dest_r);

  // Overlap weights: whole source width, or split at the output boundary
  assign w1_c = close_c ? SW'(dest_r - a_r) : d_sw;
  assign w2_c = SW'(b_c - dest_r);
  assign p1_c = SUMW'($signed({1'b0, w1_c})) * SUMW'(s_r);
  assign p2_c = SUMW'($signed({1'b0, w2_c})) * SUMW'(s_r);

  assign total_c = sum_r + p1_r;

  // Capture sample, products and flags
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s_r <= in_sample;
    end
    if (cmd.mul) begin
      b_r     <= b_c;
      p1_r    <= p1_c;
      p2_r    <= p2_c;
      last_f  <= last_c;
      inv_f   <= inv_c;
      close_f <= close_c;
    end
    if (cmd.add) begin
      total_r <= total_c;
    end
    if (cmd.div_load) begin
      neg_r <= total_r[SUMW-1];
    end
  end

  // Advance or restart the frame
  always_comb begin
    idx_nxt  = idx_r;
    a_nxt    = a_r;
    dest_nxt = dest_r;
    sum_nxt  = sum_r;
    if (cmd.add) begin
      if (last_f) begin
        idx_nxt  = '0;
        a_nxt    = '0;
        dest_nxt = EW'(s_eff);
        sum_nxt  = '0;
      end else begin
        idx_nxt = idx_r + SW'(1);
        if (!inv_f) begin
          a_nxt = b_r;
          if (close_f) begin
            dest_nxt = dest_r + EW'(s_eff);
            sum_nxt  = p2_r;
          end else begin
            sum_nxt = total_c;
          end
        end
      end
    end
    if (cfg_hit) begin
      idx_nxt  = '0;
      a_nxt    = '0;
      dest_nxt = EW'(s_eff_new);
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= SRC_RESET;
      dst_r  <= DST_RESET;
      idx_r  <= '0;
      a_r    <= '0;
      dest_r <= EW'(eff_src(SRC_RESET));
      sum_r  <= '0;
    end else begin
      src_r  <= src_nxt;
      dst_r  <= dst_nxt;
      idx_r  <= idx_nxt;
      a_r    <= a_nxt;
      dest_r <= dest_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Rounded divide: floor((2|sum| + S) / 2S), divisor pre-shifted to the top bit
  assign mag_c  = total_r[SUMW-1] ? SUMW'(-total_r) : SUMW'(total_r);
  assign num_c  = (mag_c << 1) + SUMW'(s_eff);
  assign den_sh = SUMW'(s_eff) << SAMPLE_BITS;

  awd_div #(
    .NUM_W (SUMW),
    .QUO_W (SAMPLE_BITS)
  ) u_div (
    .clk    (clk),
    .load   (cmd.div_load),
    .step   (cmd.div_step),
    .num    (num_c),
    .den_sh (den_sh),
    .quo    (quo)
  );

  assign val_c = inv_f ? '0 : (neg_r ? (~quo + SAMPLE_BITS'(1)) : quo);

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r  <= val_c;
      out_last_r   <= last_f;
      out_status_r <= inv_f;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = $signed(out_value_r);
  assign out_last_of_frame = out_last_r;
  assign out_status        = out_status_r;

  assign sts.close    = close_f;
  assign sts.err      = inv_f && last_f;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ===== sv/awd_ctrl.sv =====
// Controller state machine: sequences capture, multiply, accumulate,
// divide and emit. Uses awd_pkg; drives the datapath awd_dp by commands.
module awd_ctrl #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  awd_pkg::awd_sts_t sts,
  output awd_pkg::awd_cmd_t cmd
);
  import awd_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_BITS);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        cmd.take   = in_valid;
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (sts.close) begin
          state_nxt = ST_PREP;
        end else if (sts.err) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PREP: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SAMPLE_BITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/area_weighted_downsampler.sv =====
// Top level of the area-weighted box downsampler.
// Depends on awd_pkg, awd_ctrl, awd_dp (and awd_div through awd_dp).
//
//   channel   handshake             payload
//   in        in_valid / in_stall    in_sample
//   out       out_valid / out_stall  out_value, out_last_of_frame, out_status
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample that closes no output passes through capture, multiply and accumulate;
// one that closes an output then loads the divider, which produces one quotient bit
// per cycle, and emits. An invalid-count error goes from accumulate straight to emit.
// Reset is synchronous, active low: src_count 2, dst_count 1, frame restarts.
// The output register holds one result; the next sample is taken while it
// waits, and the block waits only when a new result finds it still full.
module area_weighted_downsampler #(
  parameter int MAX_COUNT = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          out_last_of_frame,
  output logic                          out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [awd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [awd_pkg::CFG_W-1:0]     cfg_data
);
  import awd_pkg::*;

  awd_cmd_t cmd;
  awd_sts_t sts;

  // Sequencer
  awd_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state
  awd_dp #(
    .MAX_COUNT   (MAX_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample         (in_sample),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_value         (out_value),
    .out_last_of_frame (out_last_of_frame),
    .out_status        (out_status)
  );

endmodule

// ===== sv/awd_checker.sv =====
// Port-level checks for the area-weighted downsampler, bound to the top level.
// Depends only on the top level's port names, connected through the bind.
module awd_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_value,
  input logic                          out_last_of_frame,
  input logic                          out_status,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value)
      && $stable(out_last_of_frame) && $stable(out_status))
    else $error("stalled result changed");

  // Error results carry zero and close the frame
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_value == '0 && out_last_of_frame)
    else $error("malformed error result");

  // Drop any result after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

  // A taken request leaves the block busy in the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("block not busy after request");

  // Configuration only while no sample is in flight
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid || !cfg_valid |-> cfg_ready == !in_stall)
    else $error("config ready while busy");

endmodule

bind area_weighted_downsampler awd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_awd_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for area_weighted_downsampler: directed and random frames checked
// against an overlap-weighted averaging predictor. Depends on awd_pkg and the RTL.
module tb_top;
  import awd_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int MAX_SRC = 4096;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 600;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_of_frame;
    logic                       status;
  } ds_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_value;
  logic out_last_of_frame;
  logic out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_SRC_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and frame state
  logic [CFG_W-1:0] model_src;
  logic [CFG_W-1:0] model_dst;
  logic [11:0] pos_in_frame;
  logic [24:0] src_edge;
  logic [24:0] dst_edge;
  logic signed [28:0] acc_sum;
  logic [11:0] outs_in_frame;

  ds_result_t pending_q[$];
  ds_result_t head_res;
  int mismatches = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int stall_roll;

  area_weighted_downsampler #(
    .MAX_COUNT(MAX_SRC),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_last_of_frame(out_last_of_frame),
    .out_status(out_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [CFG_W-1:0] effective_src();
    if (model_src == 0) return CFG_W'(1);
    if (model_src > MAX_SRC) return CFG_W'(MAX_SRC);
    return model_src;
  endfunction

  function automatic void restart_frame();
    pos_in_frame = '0;
    src_edge = '0;
    dst_edge = 25'(effective_src());
    acc_sum = '0;
    outs_in_frame = '0;
  endfunction

  function automatic void apply_reg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_SRC_COUNT: model_src = val;
      REG_DST_COUNT: model_dst = val;
      default: return;
    endcase
    restart_frame();
  endfunction

  // Divide by the source count, round half away from zero
  function automatic logic signed [SAMPLE_W-1:0] rounded_mean(
    input logic signed [28:0] sum, input logic [CFG_W-1:0] s_eff);
    logic [31:0] mag;
    logic [31:0] quo;
    mag = (sum < 0) ? 32'(-sum) : 32'(sum);
    quo = ({mag[30:0], 1'b0} + 32'(s_eff)) / {18'b0, s_eff, 1'b0};
    return (sum < 0) ? -quo[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
  endfunction

  function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] smp);
    logic [CFG_W-1:0] s_eff;
    logic [24:0] seg_end;
    logic [CFG_W-1:0] w_close;
    logic [CFG_W-1:0] w_carry;
    logic frame_end;
    ds_result_t res;
    s_eff = effective_src();
    frame_end = ({1'b0, pos_in_frame} + 13'd1) >= s_eff;
    // Invalid counts: only count samples, flag the frame at its end
    if (model_dst == 0 || model_dst >= s_eff) begin
      if (frame_end) begin
        res.value = '0;
        res.last_of_frame = 1'b1;
        res.status = 1'b1;
        pending_q.push_back(res);
        restart_frame();
      end else begin
        pos_in_frame++;
      end
      return;
    end
    seg_end = src_edge + 25'(model_dst);
    if (seg_end < dst_edge) begin
      acc_sum += $signed({16'b0, model_dst}) * smp;
    end else begin
      // Close the output, carry the remaining overlap into the next one
      w_close = CFG_W'(dst_edge - src_edge);
      acc_sum += $signed({16'b0, w_close}) * smp;
      res.value = rounded_mean(acc_sum, s_eff);
      res.last_of_frame = frame_end;
      res.status = 1'b0;
      pending_q.push_back(res);
      w_carry = CFG_W'(seg_end - dst_edge);
      acc_sum = $signed({16'b0, w_carry}) * smp;
      dst_edge += 25'(s_eff);
      outs_in_frame++;
    end
    src_edge = seg_end;
    if (frame_end) restart_frame();
    else pos_in_frame++;
  endfunction

  // Track accepted requests and register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) predict_sample(in_sample);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value %0d last %0b status %0b",
                 $time, out_value, out_last_of_frame, out_status);
        mismatches++;
      end else begin
        head_res = pending_q.pop_front();
        if (out_value !== head_res.value) begin
          $display("%0t: value expected %0d, got %0d", $time, head_res.value, out_value);
          mismatches++;
        end
        if (out_last_of_frame !== head_res.last_of_frame) begin
          $display("%0t: last_of_frame expected %0b, got %0b",
                   $time, head_res.last_of_frame, out_last_of_frame);
          mismatches++;
        end
        if (out_status !== head_res.status) begin
          $display("%0t: status expected %0b, got %0b", $time, head_res.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Stall the result channel in random stretches, short mostly, some long
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 12);
      end else if (stall_roll < 90) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 50);
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return SAMPLE_W'($urandom);
  endfunction

  // Send one request and hold it until accepted
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  // Reset settings give a two-sample mean; exercise rounding ties both ways
  task automatic test_reset_defaults();
    send_sample(16'sd1);
    send_sample(16'sd2);
    send_sample(-16'sd1);
    send_sample(-16'sd2);
  endtask

  // Fractional overlaps with full-scale samples
  task automatic test_partial_overlap();
    write_reg(REG_SRC_COUNT, 13'd5);
    write_reg(REG_DST_COUNT, 13'd2);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sd7);
    send_sample(16'sh8000);
    write_reg(REG_SRC_COUNT, 13'd3);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
  endtask

  // Zero outputs, zero source count, and output count equal to source count
  task automatic test_invalid_counts();
    write_reg(REG_DST_COUNT, 13'd0);
    send_sample(16'sd100);
    send_sample(-16'sd5);
    send_sample(16'sh7FFF);
    write_reg(REG_SRC_COUNT, 13'd0);
    write_reg(REG_DST_COUNT, 13'd1);
    send_sample(16'sd1);
    send_sample(16'sh8000);
    write_reg(REG_SRC_COUNT, 13'd2);
    write_reg(REG_DST_COUNT, 13'd2);
    send_sample(16'sd3);
    send_sample(16'sd4);
  endtask

  // Source count saturates at the maximum; all-ones and top-bit register data
  task automatic test_count_limits();
    write_reg(REG_SRC_COUNT, 13'h1FFF);
    write_reg(REG_DST_COUNT, 13'd4095);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd1234);
    write_reg(REG_DST_COUNT, 13'h1000);
    send_sample(16'sd9);
    write_reg(REG_SRC_COUNT, 13'h1000);
    write_reg(REG_DST_COUNT, 13'd4095);
    send_sample(-16'sd9);
  endtask

  // Random settings and whole frames of random samples
  task automatic test_random_frames();
    int sent;
    int frame_no;
    int frames;
    int r;
    int pause_at;
    logic [CFG_W-1:0] s_new;
    logic [CFG_W-1:0] d_new;
    sent = 0;
    frame_no = 0;
    while (sent < RANDOM_ITEMS) begin
      // Mostly small frames, now and then a long one
      r = $urandom_range(0, 99);
      if (r < 80) s_new = CFG_W'($urandom_range(1, 12));
      else if (r < 97) s_new = CFG_W'($urandom_range(13, 40));
      else s_new = CFG_W'($urandom_range(100, 200));
      if (s_new > 1 && $urandom_range(0, 99) < 85) d_new = CFG_W'($urandom_range(1, s_new - 1));
      else if ($urandom_range(0, 1) == 0) d_new = '0;
      else d_new = s_new + CFG_W'($urandom_range(0, 2));
      quiet = 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_SRC_COUNT, s_new);
        write_reg(REG_DST_COUNT, d_new);
      end else begin
        write_reg(REG_DST_COUNT, d_new);
        write_reg(REG_SRC_COUNT, s_new);
      end
      quiet = ($urandom_range(0, 4) == 0);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        pause_at = (frame_no % 5 == 0) ? int'(s_new) / 2 : -1;
        for (int i = 0; i < int'(s_new); i++) begin
          // Hold off mid-frame until the block has delivered everything
          if (i == pause_at) drain_results();
          send_sample(random_sample());
          sent++;
        end
        frame_no++;
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    model_src = SRC_RESET;
    model_dst = DST_RESET;
    restart_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_partial_overlap();
    test_invalid_counts();
    test_count_limits();
    test_random_frames();
    drain_results();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
